// ===== rtl/core/delta_timer_queue_top_defines.svh =====
// assertion macros for the timer queue rtl, included by dtq_ctrl
`ifndef DELTA_TIMER_QUEUE_TOP_DEFINES_SVH
`define DELTA_TIMER_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DTQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dtq_pkg.sv =====
package dtq_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_PEEK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } state_t;

    // finished-command status handed from the sequencer to the output stage
    typedef struct packed {
        logic done;
        logic found;
        logic full;
    } done_t;

endpackage

// ===== rtl/core/dtq_ram.sv =====
module dtq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/dtq_ctrl.sv =====
`include "delta_timer_queue_top_defines.svh"

module dtq_ctrl #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    cmd,
    input  logic [ID_BITS-1:0]            entry_id,
    input  logic [TIME_BITS-1:0]          delay,
    input  logic                          out_free,
    output dtq_pkg::done_t                status,
    output logic [$clog2(DEPTH+1)-1:0]    count,
    output logic [ID_BITS-1:0]            head_id,
    output logic [TIME_BITS-1:0]          head_delta
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ID_BITS + TIME_BITS;

    dtq_pkg::state_t state_reg, state_next;
    dtq_pkg::cmd_t   cmd_reg, cmd_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [TIME_BITS-1:0] delay_reg, delay_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        proc_reg, proc_next;
    logic [TIME_BITS-1:0] acc_reg, acc_next;
    logic                 placed_reg, placed_next;
    logic                 first_reg, first_next;
    logic [ID_BITS-1:0]   carry_id_reg, carry_id_next;
    logic [TIME_BITS-1:0] carry_delta_reg, carry_delta_next;
    logic                 found_reg, found_next;
    logic                 full_reg, full_next;
    logic [ID_BITS-1:0]   head_id_reg;
    logic [TIME_BITS-1:0] head_delta_reg;

    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic [EW-1:0]        rd_data;

    logic [ID_BITS-1:0]   e_id;
    logic [TIME_BITS-1:0] e_delta;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS:0]   succ_rest;
    logic [TIME_BITS:0]   merged;
    logic [TIME_BITS-1:0] merged_sat;
    logic [CW-1:0]        proc_inc;
    logic [CW-1:0]        proc_dec;
    logic [CW-1:0]        count_dec;

    dtq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign e_id       = rd_data[EW-1:TIME_BITS];
    assign e_delta    = rd_data[TIME_BITS-1:0];
    // running expiry up to and including the entry just read
    assign sum        = {1'b0, acc_reg} + {1'b0, e_delta};
    assign succ_rest  = sum - {1'b0, delay_reg};
    assign merged     = {1'b0, e_delta} + {1'b0, carry_delta_reg};
    assign merged_sat = merged[TIME_BITS] ? {TIME_BITS{1'b1}} : merged[TIME_BITS-1:0];
    assign proc_inc   = proc_reg + 1'b1;
    assign proc_dec   = proc_reg - 1'b1;
    assign count_dec  = count_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dtq_pkg::ST_IDLE;
            count_reg  <= '0;
            proc_reg   <= '0;
            placed_reg <= 1'b0;
            first_reg  <= 1'b0;
            found_reg  <= 1'b0;
            full_reg   <= 1'b0;
            cmd_reg    <= dtq_pkg::CMD_PEEK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            proc_reg   <= proc_next;
            placed_reg <= placed_next;
            first_reg  <= first_next;
            found_reg  <= found_next;
            full_reg   <= full_next;
            cmd_reg    <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        delay_reg       <= delay_next;
        acc_reg         <= acc_next;
        carry_id_reg    <= carry_id_next;
        carry_delta_reg <= carry_delta_next;
        // head copy mirrors slot zero
        if (wr_en && (wr_addr == '0))
        begin
            head_id_reg    <= wr_data[EW-1:TIME_BITS];
            head_delta_reg <= wr_data[TIME_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        id_next          = id_reg;
        delay_next       = delay_reg;
        count_next       = count_reg;
        proc_next        = proc_reg;
        acc_next         = acc_reg;
        placed_next      = placed_reg;
        first_next       = first_reg;
        carry_id_next    = carry_id_reg;
        carry_delta_next = carry_delta_reg;
        found_next       = found_reg;
        full_next        = full_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;
        rd_en            = 1'b0;
        rd_addr          = '0;
        status           = '0;

        unique case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = dtq_pkg::cmd_t'(cmd);
                    id_next     = entry_id;
                    delay_next  = delay;
                    proc_next   = '0;
                    acc_next    = '0;
                    placed_next = 1'b0;
                    first_next  = 1'b0;
                    found_next  = 1'b0;
                    full_next   = 1'b0;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                    unique case (dtq_pkg::cmd_t'(cmd))
                        dtq_pkg::CMD_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                full_next  = 1'b1;
                                state_next = dtq_pkg::ST_FIN;
                            end
                            else
                            begin
                                state_next = dtq_pkg::ST_WALK;
                            end
                        end
                        dtq_pkg::CMD_REMOVE:
                        begin
                            state_next = (count_reg == '0) ? dtq_pkg::ST_FIN
                                                           : dtq_pkg::ST_WALK;
                        end
                        dtq_pkg::CMD_TICK:
                        begin
                            // saturate at zero
                            if ((count_reg != '0) && (head_delta_reg != '0))
                            begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_data = {head_id_reg, head_delta_reg - 1'b1};
                            end
                            state_next = dtq_pkg::ST_FIN;
                        end
                        dtq_pkg::CMD_PEEK:
                        begin
                            state_next = dtq_pkg::ST_FIN;
                        end
                        default:
                        begin
                            state_next = dtq_pkg::ST_FIN;
                        end
                    endcase
                end
            end

            dtq_pkg::ST_WALK:
            begin
                rd_en     = 1'b1;
                rd_addr   = proc_inc[IW-1:0];
                proc_next = proc_inc;
                if (cmd_reg == dtq_pkg::CMD_INSERT)
                begin
                    wr_addr = proc_reg[IW-1:0];
                    if (proc_reg == count_reg)
                    begin
                        // tail slot: new entry or the last carried one
                        wr_en      = 1'b1;
                        wr_data    = placed_reg ? {carry_id_reg, carry_delta_reg}
                                                : {id_reg, delay_reg - acc_reg};
                        count_next = count_reg + 1'b1;
                        state_next = dtq_pkg::ST_FIN;
                    end
                    else if (!placed_reg)
                    begin
                        if (sum <= {1'b0, delay_reg})
                        begin
                            acc_next = sum[TIME_BITS-1:0];
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            wr_data          = {id_reg, delay_reg - acc_reg};
                            placed_next      = 1'b1;
                            carry_id_next    = e_id;
                            carry_delta_next = succ_rest[TIME_BITS-1:0];
                        end
                    end
                    else
                    begin
                        // ripple entries up by one slot
                        wr_en            = 1'b1;
                        wr_data          = {carry_id_reg, carry_delta_reg};
                        carry_id_next    = e_id;
                        carry_delta_next = e_delta;
                    end
                end
                else
                begin
                    wr_addr = proc_dec[IW-1:0];
                    if (!placed_reg)
                    begin
                        if (e_id == id_reg)
                        begin
                            placed_next      = 1'b1;
                            first_next       = 1'b1;
                            carry_delta_next = e_delta;
                        end
                    end
                    else
                    begin
                        // ripple entries down; successor absorbs the removed delta
                        wr_en      = 1'b1;
                        wr_data    = {e_id, first_reg ? merged_sat : e_delta};
                        first_next = 1'b0;
                    end
                    if (proc_reg == count_dec)
                    begin
                        found_next = placed_next;
                        if (placed_next)
                        begin
                            count_next = count_dec;
                        end
                        state_next = dtq_pkg::ST_FIN;
                    end
                end
            end

            dtq_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    status.done  = 1'b1;
                    status.found = found_reg;
                    status.full  = full_reg;
                    state_next   = dtq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dtq_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall   = (state_reg != dtq_pkg::ST_IDLE);
    assign count      = count_reg;
    assign head_id    = head_id_reg;
    assign head_delta = head_delta_reg;

    `DTQ_ASSERT_NEXT(a_full_drop, (state_reg == dtq_pkg::ST_IDLE) && in_valid && (cmd == dtq_pkg::CMD_INSERT) && (count_reg == CW'(DEPTH)), (state_reg == dtq_pkg::ST_FIN) && full_reg && (count_reg == CW'(DEPTH)), "insert into full queue not dropped")
    `DTQ_ASSERT_IMPL(a_count_walk, count_reg != $past(count_reg), $past(state_reg) == dtq_pkg::ST_WALK, "entry count changed outside a walk")
    `DTQ_ASSERT_IMPL(a_walk_bound, state_reg == dtq_pkg::ST_WALK, proc_reg <= count_reg, "walk ran past the last entry")
    `DTQ_ASSERT_IMPL(a_count_max, 1'b1, count_reg <= CW'(DEPTH), "entry count above depth")

endmodule

// ===== rtl/core/delta_timer_queue_top.sv =====
// Delta-list timer queue. Entries live in one RAM of DEPTH words, each an id and its
// delay relative to the entry before it; the head's delta is its own remaining time.
// Insert and remove walk the list one RAM entry per cycle (one read, one write-back);
// tick and peek need no walk. A new command is taken only once the previous one has
// handed its result to an output register, so the next command can be taken while
// that result is still stalled there. No clearing pass is needed after reset. Every
// command returns one result beat with the head state after the command, plus found
// (remove) and full_error (insert into a full queue, which is dropped).
module delta_timer_queue_top #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           cmd,
    input  logic [ID_BITS-1:0]   entry_id,
    input  logic [TIME_BITS-1:0] delay,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 head_valid,
    output logic [ID_BITS-1:0]   head_id,
    output logic                 head_expired,
    output logic                 found,
    output logic                 full_error
);

    localparam int CW = $clog2(DEPTH + 1);

    dtq_pkg::done_t       status;
    logic [CW-1:0]        count;
    logic [ID_BITS-1:0]   q_head_id;
    logic [TIME_BITS-1:0] q_head_delta;
    logic                 out_free;

    logic                 out_valid_reg;
    logic                 head_valid_reg;
    logic [ID_BITS-1:0]   head_id_reg;
    logic                 head_expired_reg;
    logic                 found_reg;
    logic                 full_error_reg;

    dtq_ctrl #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .entry_id   (entry_id),
        .delay      (delay),
        .out_free   (out_free),
        .status     (status),
        .count      (count),
        .head_id    (q_head_id),
        .head_delta (q_head_delta)
    );

    // result slot frees up as the waiting beat is taken
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (status.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
        begin
            head_valid_reg   <= (count != '0);
            head_id_reg      <= (count != '0) ? q_head_id : '0;
            head_expired_reg <= (count != '0) && (q_head_delta == '0);
            found_reg        <= status.found;
            full_error_reg   <= status.full;
        end
    end

    assign out_valid    = out_valid_reg;
    assign head_valid   = head_valid_reg;
    assign head_id      = head_id_reg;
    assign head_expired = head_expired_reg;
    assign found        = found_reg;
    assign full_error   = full_error_reg;

endmodule
